>>> src/hbrb_pkg.sv
// shared types and constants of the host bus to ram port bridge
`default_nettype none

package hbrb_pkg;

	localparam int ADDR_BITS = 16;
	localparam int TAG_BITS  = 5;
	localparam int WORD_BITS = 8;

	// control phase of the single operation in flight
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_DATA = 2'd1,
		PH_RESP = 2'd2
	} phase_t;

	// ram result kind codes
	localparam logic [1:0] RK_NONE  = 2'd0;
	localparam logic [1:0] RK_READ  = 2'd1;
	localparam logic [1:0] RK_WRITE = 2'd2;

	// host_ready bit positions
	localparam int HR_RD = 0;
	localparam int HR_WR = 1;

	// one input word: the sampled bus and ram port for one cycle step
	typedef struct packed {
		logic                 wr_req_valid;
		logic [ADDR_BITS-1:0] wr_req_addr;
		logic [TAG_BITS-1:0]  wr_req_tag;
		logic                 rd_req_valid;
		logic [ADDR_BITS-1:0] rd_req_addr;
		logic [TAG_BITS-1:0]  rd_req_tag;
		logic                 wr_data_valid;
		logic [WORD_BITS-1:0] wr_data_word;
		logic [1:0]           host_ready;
		logic [1:0]           ram_result_kind;
		logic [TAG_BITS-1:0]  ram_result_tag;
		logic [WORD_BITS-1:0] ram_read_word;
	} item_t;

	// one result word
	typedef struct packed {
		logic [2:0]           accept_ready;
		logic                 rd_resp_valid;
		logic [TAG_BITS-1:0]  rd_resp_tag;
		logic [WORD_BITS-1:0] rd_resp_word;
		logic                 wr_ack_valid;
		logic [TAG_BITS-1:0]  wr_ack_tag;
		logic                 ram_cmd_valid;
		logic                 ram_cmd_write;
		logic [ADDR_BITS-1:0] ram_cmd_addr;
		logic [TAG_BITS-1:0]  ram_cmd_tag;
		logic [WORD_BITS-1:0] ram_cmd_data;
	} result_t;

endpackage

`default_nettype wire

>>> src/handshake_bus_to_ram_port_bridge_top.sv
// top level of the host bus to ram port bridge with input and result registers
//
// usage:
//  - each input word is one cycle's sample of the host bus (request, data and
//    response-ready lines) and of the ram port's result lines; it arrives on
//    in_valid/in_ready, each field a port of its own
//  - each input word yields exactly one result word on out_valid/out_ready:
//    the ready bits of the three host buffers, the held read data and write
//    response, and the command driven to the ram port
//  - an accepted word is held in the input register, worked on by the core,
//    and its result is loaded into the result register that drives out_valid
//  - throughput: one word per cycle; the input register advances whenever
//    the result register is empty or being drained in the same cycle
//  - when the receiver stalls, the result register holds and the input
//    register fills; in_ready then drops until out_ready returns
//  - reset (arst_n low) empties both registers and clears all channel
//    buffers, the phase, the arbiter priority (writes first) and the grant
`default_nettype none

module handshake_bus_to_ram_port_bridge_top
	import hbrb_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 in_valid,
	output      logic                 in_ready,
	input  wire logic                 wr_req_valid,
	input  wire logic [ADDR_BITS-1:0] wr_req_addr,
	input  wire logic [TAG_BITS-1:0]  wr_req_tag,
	input  wire logic                 rd_req_valid,
	input  wire logic [ADDR_BITS-1:0] rd_req_addr,
	input  wire logic [TAG_BITS-1:0]  rd_req_tag,
	input  wire logic                 wr_data_valid,
	input  wire logic [WORD_BITS-1:0] wr_data_word,
	input  wire logic [1:0]           host_ready,
	input  wire logic [1:0]           ram_result_kind,
	input  wire logic [TAG_BITS-1:0]  ram_result_tag,
	input  wire logic [WORD_BITS-1:0] ram_read_word,

	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      logic [2:0]           accept_ready,
	output      logic                 rd_resp_valid,
	output      logic [TAG_BITS-1:0]  rd_resp_tag,
	output      logic [WORD_BITS-1:0] rd_resp_word,
	output      logic                 wr_ack_valid,
	output      logic [TAG_BITS-1:0]  wr_ack_tag,
	output      logic                 ram_cmd_valid,
	output      logic                 ram_cmd_write,
	output      logic [ADDR_BITS-1:0] ram_cmd_addr,
	output      logic [TAG_BITS-1:0]  ram_cmd_tag,
	output      logic [WORD_BITS-1:0] ram_cmd_data
);

	// input register
	logic    valid_s1;
	item_t   item_s1;

	// result register
	logic    res_valid_q;
	result_t res_q;

	result_t res_c;
	logic    step;
	logic    in_take;

	// the core steps once per word, when its result has a place to go
	assign step     = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.wr_req_valid    <= wr_req_valid;
			item_s1.wr_req_addr     <= wr_req_addr;
			item_s1.wr_req_tag      <= wr_req_tag;
			item_s1.rd_req_valid    <= rd_req_valid;
			item_s1.rd_req_addr     <= rd_req_addr;
			item_s1.rd_req_tag      <= rd_req_tag;
			item_s1.wr_data_valid   <= wr_data_valid;
			item_s1.wr_data_word    <= wr_data_word;
			item_s1.host_ready      <= host_ready;
			item_s1.ram_result_kind <= ram_result_kind;
			item_s1.ram_result_tag  <= ram_result_tag;
			item_s1.ram_read_word   <= ram_read_word;
		end
	end

	hbrb_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.res    (res_c)
	);

	// result register: loads on a step, empties when taken with nothing behind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_c;
		end
	end

	assign out_valid     = res_valid_q;
	assign accept_ready  = res_q.accept_ready;
	assign rd_resp_valid = res_q.rd_resp_valid;
	assign rd_resp_tag   = res_q.rd_resp_tag;
	assign rd_resp_word  = res_q.rd_resp_word;
	assign wr_ack_valid  = res_q.wr_ack_valid;
	assign wr_ack_tag    = res_q.wr_ack_tag;
	assign ram_cmd_valid = res_q.ram_cmd_valid;
	assign ram_cmd_write = res_q.ram_cmd_write;
	assign ram_cmd_addr  = res_q.ram_cmd_addr;
	assign ram_cmd_tag   = res_q.ram_cmd_tag;
	assign ram_cmd_data  = res_q.ram_cmd_data;

`ifndef SYNTHESIS
	// a stalled result with a full input register must block the input
	a_block_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid_q && !out_ready |-> !in_ready)
		else $error("input taken while both registers are full");

	// a step always leaves a result behind
	a_step_fills: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> res_valid_q)
		else $error("step did not produce a result");

	// a stalled result holds its command word
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !out_ready |=> res_valid_q && $stable(res_q))
		else $error("stalled result changed");

	// write command flag only with a command
	a_cmd_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (!res_q.ram_cmd_write || res_q.ram_cmd_valid))
		else $error("write flag without a command");
`endif

endmodule

`default_nettype wire

>>> src/hbrb_core.sv
// bridge state: channel buffers, arbiter and phase control, one step per word
`default_nettype none

module hbrb_core
	import hbrb_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    step,
	input  wire item_t   item,
	output      result_t res
);

	phase_t               phase_q, phase_d;
	logic                 busy_rd_q, busy_rd_d;
	logic                 rd_first_q, rd_first_d;
	logic                 wreq_v_q, wreq_v_d;
	logic [ADDR_BITS-1:0] wreq_addr_q, wreq_addr_d;
	logic [TAG_BITS-1:0]  wreq_tag_q, wreq_tag_d;
	logic                 rreq_v_q, rreq_v_d;
	logic [ADDR_BITS-1:0] rreq_addr_q, rreq_addr_d;
	logic [TAG_BITS-1:0]  rreq_tag_q, rreq_tag_d;
	logic                 wdat_v_q, wdat_v_d;
	logic [WORD_BITS-1:0] wdat_word_q, wdat_word_d;
	logic                 rresp_v_q, rresp_v_d;
	logic [TAG_BITS-1:0]  rresp_tag_q, rresp_tag_d;
	logic [WORD_BITS-1:0] rresp_word_q, rresp_word_d;
	logic                 ack_v_q, ack_v_d;
	logic [TAG_BITS-1:0]  ack_tag_q, ack_tag_d;
	logic [ADDR_BITS-1:0] gnt_addr_q, gnt_addr_d;
	logic [TAG_BITS-1:0]  gnt_tag_q, gnt_tag_d;

	logic do_read, wr_grant, issue_wr;

	// arbitration and write issue decisions
	always_comb begin
		do_read  = 1'b0;
		wr_grant = 1'b0;
		issue_wr = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (rd_first_q) begin
					do_read  = rreq_v_q;
					wr_grant = !rreq_v_q && wreq_v_q;
				end else begin
					wr_grant = wreq_v_q;
					do_read  = !wreq_v_q && rreq_v_q;
				end
			end
			PH_DATA: begin
				issue_wr = !busy_rd_q && wdat_v_q;
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		phase_d      = phase_q;
		busy_rd_d    = busy_rd_q;
		rd_first_d   = rd_first_q;
		wreq_v_d     = wreq_v_q;
		wreq_addr_d  = wreq_addr_q;
		wreq_tag_d   = wreq_tag_q;
		rreq_v_d     = rreq_v_q;
		rreq_addr_d  = rreq_addr_q;
		rreq_tag_d   = rreq_tag_q;
		wdat_v_d     = wdat_v_q;
		wdat_word_d  = wdat_word_q;
		rresp_v_d    = rresp_v_q;
		rresp_tag_d  = rresp_tag_q;
		rresp_word_d = rresp_word_q;
		ack_v_d      = ack_v_q;
		ack_tag_d    = ack_tag_q;
		gnt_addr_d   = gnt_addr_q;
		gnt_tag_d    = gnt_tag_q;

		if (item.host_ready[HR_RD]) begin
			rresp_v_d = 1'b0;
		end
		if (item.host_ready[HR_WR]) begin
			ack_v_d = 1'b0;
		end

		if (do_read) begin
			busy_rd_d  = 1'b1;
			gnt_addr_d = rreq_addr_q;
			gnt_tag_d  = rreq_tag_q;
			rreq_v_d   = 1'b0;
			rd_first_d = 1'b0;
			phase_d    = PH_DATA;
		end else if (wr_grant) begin
			busy_rd_d  = 1'b0;
			gnt_addr_d = wreq_addr_q;
			gnt_tag_d  = wreq_tag_q;
			wreq_v_d   = 1'b0;
			rd_first_d = 1'b1;
			phase_d    = PH_DATA;
		end else if (issue_wr) begin
			wdat_v_d = 1'b0;
			phase_d  = PH_RESP;
		end

		// ram results land in the response buffers whatever the phase
		case (item.ram_result_kind)
			RK_READ: begin
				rresp_v_d    = 1'b1;
				rresp_tag_d  = item.ram_result_tag;
				rresp_word_d = item.ram_read_word;
			end
			RK_WRITE: begin
				ack_v_d   = 1'b1;
				ack_tag_d = item.ram_result_tag;
			end
			default: begin
			end
		endcase

		// completion sees the phase after this step's grant
		if (phase_d == PH_DATA && busy_rd_d) begin
			if (rresp_v_q && item.host_ready[HR_RD]) begin
				phase_d = PH_IDLE;
			end
		end else if (phase_d == PH_RESP) begin
			if (ack_v_q && item.host_ready[HR_WR]) begin
				phase_d = PH_IDLE;
			end
		end

		// empty buffers reload the whole channel
		if (!wreq_v_q) begin
			wreq_v_d    = item.wr_req_valid;
			wreq_addr_d = item.wr_req_addr;
			wreq_tag_d  = item.wr_req_tag;
		end
		if (!rreq_v_q) begin
			rreq_v_d    = item.rd_req_valid;
			rreq_addr_d = item.rd_req_addr;
			rreq_tag_d  = item.rd_req_tag;
		end
		if (!wdat_v_q) begin
			wdat_v_d    = item.wr_data_valid;
			wdat_word_d = item.wr_data_word;
		end
	end

	// outputs
	always_comb begin
		res.accept_ready  = {!wdat_v_q, !rreq_v_q, !wreq_v_q};
		res.rd_resp_valid = rresp_v_q;
		res.rd_resp_tag   = rresp_tag_q;
		res.rd_resp_word  = rresp_word_q;
		res.wr_ack_valid  = ack_v_q;
		res.wr_ack_tag    = ack_tag_q;
		res.ram_cmd_valid = do_read || issue_wr;
		res.ram_cmd_write = issue_wr;
		res.ram_cmd_addr  = gnt_addr_d;
		res.ram_cmd_tag   = gnt_tag_d;
		res.ram_cmd_data  = wdat_word_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			busy_rd_q    <= 1'b0;
			rd_first_q   <= 1'b0;
			wreq_v_q     <= 1'b0;
			wreq_addr_q  <= '0;
			wreq_tag_q   <= '0;
			rreq_v_q     <= 1'b0;
			rreq_addr_q  <= '0;
			rreq_tag_q   <= '0;
			wdat_v_q     <= 1'b0;
			wdat_word_q  <= '0;
			rresp_v_q    <= 1'b0;
			rresp_tag_q  <= '0;
			rresp_word_q <= '0;
			ack_v_q      <= 1'b0;
			ack_tag_q    <= '0;
			gnt_addr_q   <= '0;
			gnt_tag_q    <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			busy_rd_q    <= busy_rd_d;
			rd_first_q   <= rd_first_d;
			wreq_v_q     <= wreq_v_d;
			wreq_addr_q  <= wreq_addr_d;
			wreq_tag_q   <= wreq_tag_d;
			rreq_v_q     <= rreq_v_d;
			rreq_addr_q  <= rreq_addr_d;
			rreq_tag_q   <= rreq_tag_d;
			wdat_v_q     <= wdat_v_d;
			wdat_word_q  <= wdat_word_d;
			rresp_v_q    <= rresp_v_d;
			rresp_tag_q  <= rresp_tag_d;
			rresp_word_q <= rresp_word_d;
			ack_v_q      <= ack_v_d;
			ack_tag_q    <= ack_tag_d;
			gnt_addr_q   <= gnt_addr_d;
			gnt_tag_q    <= gnt_tag_d;
		end
	end

`ifndef SYNTHESIS
	// a write command only follows a write grant, never a read one
	a_wr_not_busy_rd: assert property (@(posedge clk) disable iff (!arst_n)
		step && issue_wr |-> !busy_rd_q)
		else $error("write issued while a read is in flight");

	// a write grant always enters the data phase; a read grant may complete in the same step
	a_grant_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && wr_grant |=> phase_q == PH_DATA)
		else $error("write grant did not enter data phase");

	// priority goes to the other side after every grant: reads first after a write, writes first after a read
	a_prio_flip: assert property (@(posedge clk) disable iff (!arst_n)
		step && (do_read || wr_grant) |=> rd_first_q == $past(wr_grant))
		else $error("priority did not alternate");
`endif

endmodule

`default_nettype wire
